@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the cache top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, checked at every rising edge outside reset.
`define BB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Cause in this cycle, effect in the next.
`define BB_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ hw/rtl/bblru_pkg.sv @@
// Shared types and constants of the byte-budget LRU cache.
`default_nettype none

package bblru_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 9;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // One stored entry as it sits in a cell.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] size;
  } entry_t;

  // Signals passed cell to cell along the row.
  typedef struct packed {
    logic              seen;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] size;
  } chain_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_PULL,
    CELL_PUSH,
    CELL_DROP
  } cell_op_t;

endpackage

`default_nettype wire

@@ hw/rtl/bblru_if.sv @@
// Handshake channels of the byte-budget LRU cache.
`default_nettype none

interface bblru_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [bblru_pkg::DATA_W-1:0] key;
  logic [bblru_pkg::DATA_W-1:0] handle;
  logic [bblru_pkg::DATA_W-1:0] entry_bytes;

  modport source (output valid, func, key, handle, entry_bytes, input ready);
  modport sink (input valid, func, key, handle, entry_bytes, output ready);
endinterface

interface bblru_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [bblru_pkg::DATA_W-1:0]  found_handle;
  logic                          stored;
  logic [bblru_pkg::DATA_W-1:0]  total_bytes;
  logic [bblru_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, hit, found_handle, stored, total_bytes, entry_count,
                  input ready);
  modport sink (input valid, hit, found_handle, stored, total_bytes, entry_count,
                output ready);
endinterface

interface bblru_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bblru_pkg::DATA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bblru_cell.sv @@
// One recency slot of the cache row; cell index equals recency rank.
`default_nettype none

module bblru_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bblru_pkg::cell_op_t          op,
  input  wire logic [bblru_pkg::DATA_W-1:0] cmp_key,
  input  wire bblru_pkg::entry_t            push_in,   // from the more recent neighbor
  input  wire bblru_pkg::entry_t            pull_in,   // from the less recent neighbor
  input  wire bblru_pkg::chain_t            chain_in,
  output bblru_pkg::chain_t                 chain_out,
  output bblru_pkg::entry_t                 ent_out
);

  bblru_pkg::entry_t ent;
  logic              match;
  logic              sel;

  // selected cell drives its payload down the chain
  always_comb begin
    case (op)
      bblru_pkg::CELL_PULL: sel = match;
      bblru_pkg::CELL_DROP: sel = ent.valid & ~pull_in.valid;
      default:              sel = 1'b0;
    endcase
    chain_out.seen   = chain_in.seen | match;
    chain_out.handle = sel ? ent.handle : chain_in.handle;
    chain_out.size   = sel ? ent.size : chain_in.size;
  end

  assign ent_out = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      match     <= 1'b0;
    end else begin
      unique case (op)
        bblru_pkg::CELL_HOLD: begin
        end
        bblru_pkg::CELL_MATCH: begin
          match <= ent.valid && (ent.key == cmp_key);
        end
        bblru_pkg::CELL_PULL: begin
          // close the gap left by the matched entry
          if (chain_in.seen || match) begin
            ent <= pull_in;
          end
        end
        bblru_pkg::CELL_PUSH: begin
          ent <= push_in;
        end
        bblru_pkg::CELL_DROP: begin
          if (sel) begin
            ent.valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/byte_budget_lru_cache_unit.sv @@
// Top level of the byte-budget LRU cache: sequencer, byte/count totals and cell row.
`default_nettype none

// Byte-budget LRU cache. Entries live in a row of ENTRIES cells ordered by
// recency: cell 0 is the most recent, valid entries are packed from cell 0 on.
// Every operation starts with a parallel key compare in all cells, then the
// matched entry (if any) is pulled out of the row by shifting the older cells
// up one place. A lookup hit pushes it back in at the head; an insert that fits
// the budget pushes the new entry in at the head (after dropping the tail if
// the row is full) and then drops tail entries one per cycle while the held
// total is above byte_capacity and more than one entry remains. One item is in
// work at a time. The result sits in an output register, so the next item is
// taken while an earlier result is still waiting. byte_capacity is written
// through cfg at any time the block is idle; cfg.ready is always high, and a
// lower budget evicts nothing before the next stored insert.
`include "assert_macros.svh"

module byte_budget_lru_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bblru_req_if.sink   req,
  bblru_rsp_if.source rsp,
  bblru_cfg_if.sink   cfg
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned DW    = bblru_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_PULL,
    ST_DROP_FULL,
    ST_PUSH,
    ST_TRIM,
    ST_REPLY
  } state_t;

  state_t state;

  // item in work; handle/size are replaced by the hit entry on a lookup
  logic          item_func;
  logic [DW-1:0] item_key;
  logic [DW-1:0] item_handle;
  logic [DW-1:0] item_size;

  logic [DW-1:0]    byte_capacity;
  logic [DW:0]      held;          // one spare bit: insert may overshoot before trim
  logic [CNT_W-1:0] count;

  logic          res_hit;
  logic [DW-1:0] res_handle;
  logic          res_stored;

  bblru_pkg::cell_op_t cell_op;
  bblru_pkg::entry_t   ent   [ENTRIES];
  bblru_pkg::chain_t   chain [ENTRIES+1];
  bblru_pkg::entry_t   head_entry;
  bblru_pkg::chain_t   tail_chain;

  logic             over_budget;
  logic             fits;
  logic [CNT_W-1:0] count_after_pull;
  logic             idle_now;
  logic             trim_drop;

  // ---------------------------------------------------------------- cell row
  assign head_entry = '{valid: 1'b1, key: item_key, handle: item_handle, size: item_size};
  assign chain[0]   = '0;
  assign tail_chain = chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bblru_pkg::entry_t push_src;
    bblru_pkg::entry_t pull_src;

    if (i == 0) begin : g_head
      assign push_src = head_entry;
    end else begin : g_body
      assign push_src = ent[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign pull_src = '0;
    end else begin : g_inner
      assign pull_src = ent[i+1];
    end

    bblru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (cell_op),
      .cmp_key   (item_key),
      .push_in   (push_src),
      .pull_in   (pull_src),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .ent_out   (ent[i])
    );
  end

  // ---------------------------------------------------------------- control
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign over_budget      = (held > {1'b0, byte_capacity}) && (count > CNT_W'(1));
  assign fits             = (item_size <= byte_capacity);
  assign count_after_pull = count - CNT_W'(tail_chain.seen);
  assign idle_now         = (state == ST_IDLE);
  assign trim_drop        = (state == ST_TRIM) && over_budget;

  always_comb begin
    case (state)
      ST_FIND:      cell_op = bblru_pkg::CELL_MATCH;
      ST_PULL:      cell_op = bblru_pkg::CELL_PULL;
      ST_DROP_FULL: cell_op = bblru_pkg::CELL_DROP;
      ST_PUSH:      cell_op = bblru_pkg::CELL_PUSH;
      ST_TRIM:      cell_op = over_budget ? bblru_pkg::CELL_DROP : bblru_pkg::CELL_HOLD;
      default:      cell_op = bblru_pkg::CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held          <= '0;
      count         <= '0;
      byte_capacity <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        byte_capacity <= cfg.data;
      end
      // in ST_REPLY the output register is refilled below instead
      if (rsp.valid && rsp.ready && (state != ST_REPLY)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            item_func   <= req.func;
            item_key    <= req.key;
            item_handle <= req.handle;
            item_size   <= req.entry_bytes;
            state       <= ST_FIND;
          end
        end
        ST_FIND: begin
          state <= ST_PULL;
        end
        ST_PULL: begin
          // tail_chain carries the pulled entry and whether one matched
          if (tail_chain.seen) begin
            held  <= held - {1'b0, tail_chain.size};
            count <= count_after_pull;
          end
          res_hit    <= (item_func == bblru_pkg::FUNC_LOOKUP) && tail_chain.seen;
          res_handle <= ((item_func == bblru_pkg::FUNC_LOOKUP) && tail_chain.seen)
                        ? tail_chain.handle : '0;
          res_stored <= (item_func == bblru_pkg::FUNC_INSERT) && fits;
          if (item_func == bblru_pkg::FUNC_LOOKUP) begin
            if (tail_chain.seen) begin
              item_handle <= tail_chain.handle;
              item_size   <= tail_chain.size;
              state       <= ST_PUSH;
            end else begin
              state <= ST_REPLY;
            end
          end else if (!fits) begin
            state <= ST_REPLY;
          end else if (count_after_pull == CNT_W'(ENTRIES)) begin
            state <= ST_DROP_FULL;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_DROP_FULL: begin
          held  <= held - {1'b0, tail_chain.size};
          count <= count - CNT_W'(1);
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          held  <= held + {1'b0, item_size};
          count <= count + CNT_W'(1);
          state <= (item_func == bblru_pkg::FUNC_LOOKUP) ? ST_REPLY : ST_TRIM;
        end
        ST_TRIM: begin
          // one tail eviction per cycle
          if (over_budget) begin
            held  <= held - {1'b0, tail_chain.size};
            count <= count - CNT_W'(1);
          end else begin
            state <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.hit          <= res_hit;
            rsp.found_handle <= res_handle;
            rsp.stored       <= res_stored;
            rsp.total_bytes  <= held[DW-1:0];
            rsp.entry_count  <= bblru_pkg::COUNT_W'(count);
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  `BB_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(ENTRIES), "entry count above row size")
  `BB_ASSERT(a_held_fits, clk, rst, !idle_now || !held[DW], "held total overflow at idle")
  `BB_ASSERT(a_head_valid, clk, rst, !idle_now || (ent[0].valid == (count != '0)), "head vs count")
  `BB_ASSERT_NEXT(a_trim_drop, clk, rst, trim_drop, count == $past(count) - CNT_W'(1), "no evict")

endmodule

`default_nettype wire

@@ tb/tb_byte_budget_lru_cache_unit.sv @@
// Self-checking testbench of the byte-budget LRU cache: shadow-model scoreboard and drivers.
`timescale 1ns / 100ps

module tb_byte_budget_lru_cache_unit;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned KEY_POOL    = 24;    // a bit over ENTRIES: hits, misses, full row
  localparam int unsigned PHASE_ITEMS = 56;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One request item and one reply item, at the port widths.
  typedef struct packed {
    logic                         func;
    logic [bblru_pkg::DATA_W-1:0] key;
    logic [bblru_pkg::DATA_W-1:0] handle;
    logic [bblru_pkg::DATA_W-1:0] entry_bytes;
  } cache_req_t;

  typedef struct packed {
    logic                          hit;
    logic [bblru_pkg::DATA_W-1:0]  found_handle;
    logic                          stored;
    logic [bblru_pkg::DATA_W-1:0]  total_bytes;
    logic [bblru_pkg::COUNT_W-1:0] entry_count;
  } cache_reply_t;

  typedef struct packed {
    logic [bblru_pkg::DATA_W-1:0] key;
    logic [bblru_pkg::DATA_W-1:0] handle;
    logic [bblru_pkg::DATA_W-1:0] size;
  } line_t;

  // Shadow of the cache contents plus the FIFO of replies still owed by the DUT.
  // lines[0] is the most recent entry, the back of the queue the least recent.
  class cache_shadow;
    line_t        lines[$];
    logic [63:0]  held;      // wide: insert can briefly push the sum past 32 bits
    logic [31:0]  budget;
    cache_reply_t owed[$];
    int unsigned  errors;

    function new();
      held   = '0;
      budget = '0;
      errors = 0;
    endfunction

    function void set_budget(logic [31:0] value);
      budget = value;
    endfunction

    function int find_key(logic [31:0] key);
      for (int i = 0; i < lines.size(); i++)
        if (lines[i].key == key) return i;
      return -1;
    endfunction

    function void drop_line(int idx);
      held = held - lines[idx].size;
      lines.delete(idx);
    endfunction

    // Accepted request: update the shadow and queue the reply it must produce.
    function void note_request(cache_req_t r);
      cache_reply_t rep;
      line_t        ln;
      int           slot;
      rep  = '0;
      slot = find_key(r.key);
      if (r.func == bblru_pkg::FUNC_LOOKUP) begin
        if (slot >= 0) begin
          ln = lines[slot];
          lines.delete(slot);
          lines.insert(0, ln);
          rep.hit          = 1'b1;
          rep.found_handle = ln.handle;
        end
      end else begin
        if (slot >= 0) drop_line(slot);
        if (r.entry_bytes <= budget) begin
          if (lines.size() >= ENTRIES) drop_line(lines.size() - 1);
          ln.key    = r.key;
          ln.handle = r.handle;
          ln.size   = r.entry_bytes;
          lines.insert(0, ln);
          held = held + r.entry_bytes;
          // evict from the tail until we fit, but never the new entry itself
          while (held > budget && lines.size() > 1) drop_line(lines.size() - 1);
          rep.stored = 1'b1;
        end
      end
      rep.total_bytes = held[31:0];
      rep.entry_count = bblru_pkg::COUNT_W'(lines.size());
      owed.insert(owed.size(), rep);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(cache_reply_t got);
      cache_reply_t want;
      if (owed.size() == 0) begin
        $display("%0t: reply with nothing owed, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("found_handle", want.found_handle, got.found_handle);
      compare_field("stored", want.stored, got.stored);
      compare_field("total_bytes", want.total_bytes, got.total_bytes);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic clk;
  logic rst;

  bblru_req_if req_ch ();
  bblru_rsp_if rsp_ch ();
  bblru_cfg_if cfg_ch ();

  byte_budget_lru_cache_unit #(
    .ENTRIES (ENTRIES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  cache_shadow       shadow = new();
  logic [31:0]       key_pool[KEY_POOL];
  bit                quiet = 1'b0;   // no idling on either side once set
  int unsigned       cycle_count = 0;

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_byte_budget_lru_cache_unit NOT OK");
      $finish;
    end
  end

  // Reply monitor: every accepted reply is checked against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      shadow.check_reply({rsp_ch.hit, rsp_ch.found_handle, rsp_ch.stored,
                          rsp_ch.total_bytes, rsp_ch.entry_count});
  end

  // Reply side back-pressure: occasional stall bursts of random length.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 15) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic cache_req_t mk_req(logic func, logic [31:0] key, logic [31:0] handle,
                                        logic [31:0] entry_bytes);
    cache_req_t r;
    r.func        = func;
    r.key         = key;
    r.handle      = handle;
    r.entry_bytes = entry_bytes;
    return r;
  endfunction

  // Random item: keys mostly from a small pool so lookups hit and the row fills;
  // sizes mostly a fraction of the budget, some right at it, some fully random.
  function automatic cache_req_t random_req();
    cache_req_t  r;
    logic [31:0] cap;
    cap      = shadow.budget;
    r.func   = ($urandom_range(0, 1) == 1) ? bblru_pkg::FUNC_INSERT : bblru_pkg::FUNC_LOOKUP;
    r.key    = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                          : $urandom();
    r.handle = $urandom();
    case ($urandom_range(0, 9))
      0, 1: r.entry_bytes = $urandom();
      2: r.entry_bytes = cap + $urandom_range(0, 2) - 1;   // budget-1, budget, budget+1
      default: r.entry_bytes = $urandom_range(0, cap / $urandom_range(2, 40));
    endcase
    return r;
  endfunction

  function automatic void refill_pool();
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
  endfunction

  // Present one item, with an optional idle burst ahead of it; returns on accept.
  task automatic send_req(cache_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= r.func;
    req_ch.key         <= r.key;
    req_ch.handle      <= r.handle;
    req_ch.entry_bytes <= r.entry_bytes;
    do @(posedge clk); while (!req_ch.ready);
    shadow.note_request(r);
  endtask

  // Drop valid and let every owed reply drain, then idle on for a margin.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_budget(logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow.set_budget(value);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] phase_budget[8];

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= bblru_pkg::FUNC_LOOKUP;
    req_ch.key         <= '0;
    req_ch.handle      <= '0;
    req_ch.entry_bytes <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // budget is 0 out of reset: only zero-size entries fit
    send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0));
    send_req(mk_req(bblru_pkg::FUNC_LOOKUP, 32'h0, 32'h0, 32'h0));
    // oversized insert still removes the old entry of that key
    send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'h0, 32'h1, 32'h1));
    send_req(mk_req(bblru_pkg::FUNC_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    wait_idle();

    // max budget: a full-budget entry, then one more byte forces it out
    write_budget(32'hFFFF_FFFF);
    send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'h1, 32'h5A5A_A5A5, 32'h1));
    send_req(mk_req(bblru_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0));
    wait_idle();

    // fill past ENTRIES: the full row drops its least recent entry (key 1)
    write_budget(32'd100);
    for (int i = 0; i < ENTRIES; i++)
      send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'h100 + i, 32'hC000_0000 + i, i % 3));
    send_req(mk_req(bblru_pkg::FUNC_LOOKUP, 32'h100, 32'h0, 32'h0));
    send_req(mk_req(bblru_pkg::FUNC_LOOKUP, 32'h1, 32'h0, 32'h0));
    wait_idle();

    // budget lowered under the held total: nothing leaves until a stored insert
    write_budget(32'd10);
    send_req(mk_req(bblru_pkg::FUNC_LOOKUP, 32'h105, 32'h0, 32'h0));
    send_req(mk_req(bblru_pkg::FUNC_INSERT, 32'h200, 32'h3C3C_3C3C, 32'd4));
    wait_idle();

    // --- random phases, each under its own budget ---
    phase_budget = '{32'hFFFF_FFFF, 32'd1000, 32'd37, 32'd0, 32'd1, $urandom(),
                     32'd50000, 32'd255};
    for (int p = 0; p < 8; p++) begin
      if (p % 4 == 0) refill_pool();
      if (p == 7) quiet = 1'b1;
      write_budget(phase_budget[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_req(random_req());
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (shadow.errors == 0 && shadow.owed.size() == 0) begin
      $display("tb_byte_budget_lru_cache_unit OK");
    end else begin
      $display("tb_byte_budget_lru_cache_unit NOT OK");
    end
    $finish;
  end

endmodule
